@@ hdl/f2ic_pkg.sv @@
`timescale 1ns / 1ps

package f2ic_pkg;

    localparam int JoinW = 63;

    localparam logic [2:0] FMT_8  = 3'd0;
    localparam logic [2:0] FMT_10 = 3'd1;
    localparam logic [2:0] FMT_13 = 3'd2;
    localparam logic [2:0] FMT_16 = 3'd3;
    localparam logic [2:0] FMT_20 = 3'd4;

    localparam logic CFG_FORMAT = 1'b0;
    localparam logic CFG_DOUBLE = 1'b1;

    localparam logic [10:0] DBL_BIAS = 11'd1023;
    localparam logic [7:0]  SGL_BIAS = 8'd127;
    localparam logic [6:0]  DBL_LEAD = 7'd61;
    localparam logic [6:0]  SGL_LEAD = 7'd29;
    localparam logic [5:0]  DBL_SAT_OFS = 6'd32;

    typedef struct packed {
        logic             sign;
        logic             fold;
        logic             dbl;
        logic [2:0]       fmt;
        logic [JoinW-1:0] joined;
    } t_unp_s;

    typedef struct packed {
        t_unp_s     base;
        logic       zero;
        logic [5:0] pos;
    } t_lead_s;

    function automatic logic [3:0] prec_width(input logic [2:0] fmt);
        logic [3:0] w;
        unique case (fmt)
            FMT_8:   w = 4'd5;
            FMT_10:  w = 4'd6;
            FMT_13:  w = 4'd7;
            FMT_16:  w = 4'd10;
            FMT_20:  w = 4'd14;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [5:0] sat_shift(input logic [2:0] fmt);
        logic [5:0] s;
        unique case (fmt)
            FMT_8:   s = 6'd18;
            FMT_10:  s = 6'd9;
            FMT_13:  s = 6'd8;
            FMT_16:  s = 6'd5;
            FMT_20:  s = 6'd1;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/f2ic_unpack.sv @@
`timescale 1ns / 1ps

module f2ic_unpack import f2ic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_float_bits,
    input  logic [2:0]  i_fmt,
    input  logic        i_dbl,
    output logic        o_valid,
    input  logic        i_ready,
    output t_unp_s      o_data
);

    logic       r_valid;
    t_unp_s     r_data;
    t_unp_s     n_data;
    logic [10:0] w_dexp;
    logic [10:0] w_dd;
    logic [10:0] w_dfold_exp;
    logic        w_dfold;
    logic [7:0]  w_sexp;
    logic [7:0]  w_sd;
    logic [7:0]  w_sfold_exp;
    logic        w_sfold;

    assign w_dexp      = i_float_bits[62:52];
    assign w_dd        = w_dexp - DBL_BIAS;
    assign w_dfold     = (i_fmt == FMT_8) ? (w_dexp <= DBL_BIAS) : (w_dexp < DBL_BIAS);
    assign w_dfold_exp = w_dfold ? ~w_dd : w_dd;

    assign w_sexp      = i_float_bits[30:23];
    assign w_sd        = w_sexp - SGL_BIAS;
    assign w_sfold     = w_sexp < SGL_BIAS;
    assign w_sfold_exp = w_sfold ? ~w_sd : w_sd;

    always_comb begin
        n_data.dbl = i_dbl;
        n_data.fmt = i_fmt;
        if (i_dbl) begin
            n_data.sign   = i_float_bits[63];
            n_data.fold   = w_dfold;
            n_data.joined = {w_dfold_exp, i_float_bits[51:0]};
        end else begin
            n_data.sign   = i_float_bits[31];
            n_data.fold   = w_sfold;
            n_data.joined = {32'd0, w_sfold_exp, i_float_bits[22:0]};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hdl/f2ic_lead.sv @@
`timescale 1ns / 1ps

module f2ic_lead import f2ic_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_unp_s  i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_lead_s o_data
);

    logic        r_valid_a;
    t_unp_s      r_data_a;
    logic [7:0]  r_nz;
    logic [2:0]  r_gpos [8];
    logic [7:0]  n_nz;
    logic [2:0]  n_gpos [8];
    logic        w_ready_a;

    logic        r_valid_b;
    t_lead_s     r_data_b;
    t_lead_s     n_data_b;
    logic        w_ready_b;

    logic [63:0] w_word;

    assign w_word = {1'b0, i_data.joined};

    // per-byte nonzero flag and top set bit
    always_comb begin
        for (int g = 0; g < 8; g++) begin
            n_nz[g]   = |w_word[g*8 +: 8];
            n_gpos[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (w_word[g*8 + b]) begin
                    n_gpos[g] = 3'(b);
                end
            end
        end
    end

    // pick the top nonzero byte
    always_comb begin
        n_data_b.base = r_data_a;
        n_data_b.zero = ~|r_nz;
        n_data_b.pos  = 6'd0;
        for (int g = 0; g < 8; g++) begin
            if (r_nz[g]) begin
                n_data_b.pos = {3'(g), r_gpos[g]};
            end
        end
    end

    assign w_ready_b = !r_valid_b || i_ready;
    assign w_ready_a = !r_valid_a || w_ready_b;
    assign o_ready   = w_ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_valid_a <= i_valid;
            end
            if (w_ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_data_a <= i_data;
            r_nz     <= n_nz;
            r_gpos   <= n_gpos;
        end
        if (w_ready_b && r_valid_a) begin
            r_data_b <= n_data_b;
        end
    end

    assign o_valid = r_valid_b;
    assign o_data  = r_data_b;

    a_lead_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid_b && !r_data_b.zero) |-> ((r_data_b.base.joined >> r_data_b.pos) == 63'd1))
        else $error("leading one position does not match joined word");

    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid_b && r_data_b.zero) |-> (r_data_b.base.joined == '0))
        else $error("zero flag set on nonzero joined word");

endmodule

@@ hdl/f2ic_pack.sv @@
`timescale 1ns / 1ps

module f2ic_pack import f2ic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_lead_s     i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [19:0] o_index_code
);

    typedef struct packed {
        logic             sign;
        logic             fold;
        logic [2:0]       fmt;
        logic             zero;
        logic [3:0]       zc;
        logic [5:0]       shift;
        logic [JoinW-1:0] joined;
    } t_mid_s;

    logic              r_valid_a;
    t_mid_s            r_mid;
    t_mid_s            n_mid;
    logic              w_ready_a;

    logic              r_valid_b;
    logic [19:0]       r_code;
    logic [19:0]       n_code;
    logic              w_ready_b;

    logic [6:0]        w_lead;
    logic signed [7:0] w_raw;
    logic [3:0]        w_zmax;
    logic [3:0]        w_pw;
    logic              w_sat;
    logic [JoinW-1:0]  w_sh;
    logic [13:0]       w_prec;

    assign w_lead = i_data.base.dbl ? DBL_LEAD : SGL_LEAD;
    assign w_raw  = $signed({1'b0, w_lead}) - $signed({2'b00, i_data.pos});
    assign w_zmax = (i_data.base.fmt == FMT_8) ? 4'd7 : 4'd15;
    assign w_pw   = prec_width(i_data.base.fmt);
    assign w_sat  = w_raw >= $signed({4'd0, w_zmax});

    always_comb begin
        n_mid.sign   = i_data.base.sign;
        n_mid.fold   = i_data.base.fold;
        n_mid.fmt    = i_data.base.fmt;
        n_mid.zero   = i_data.zero;
        n_mid.joined = i_data.base.joined;
        if (i_data.zero || w_sat) begin
            n_mid.zc = w_zmax;
        end else if (w_raw[7]) begin
            n_mid.zc = 4'd0;
        end else begin
            n_mid.zc = w_raw[3:0];
        end
        if (w_sat) begin
            n_mid.shift = sat_shift(i_data.base.fmt) + (i_data.base.dbl ? DBL_SAT_OFS : 6'd0);
        end else if (i_data.pos < {2'b00, w_pw}) begin
            n_mid.shift = 6'd0;
        end else begin
            n_mid.shift = i_data.pos - {2'b00, w_pw};
        end
    end

    assign w_sh   = r_mid.joined >> r_mid.shift;
    assign w_prec = r_mid.zero ? 14'd0 : w_sh[13:0];

    always_comb begin
        unique case (r_mid.fmt)
            FMT_8:   n_code = {12'd0, r_mid.zc[2:0], w_prec[4:0]};
            FMT_10:  n_code = {10'd0, r_mid.zc, w_prec[5:0]};
            FMT_13:  n_code = {7'd0, r_mid.sign, r_mid.fold, r_mid.zc, w_prec[6:0]};
            FMT_16:  n_code = {4'd0, r_mid.sign, r_mid.fold, r_mid.zc, w_prec[9:0]};
            FMT_20:  n_code = {r_mid.sign, r_mid.fold, r_mid.zc, w_prec[13:0]};
            default: n_code = 20'd0;
        endcase
    end

    assign w_ready_b = !r_valid_b || i_ready;
    assign w_ready_a = !r_valid_a || w_ready_b;
    assign o_ready   = w_ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_valid_a <= i_valid;
            end
            if (w_ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_mid <= n_mid;
        end
        if (w_ready_b && r_valid_a) begin
            r_code <= n_code;
        end
    end

    assign o_valid      = r_valid_b;
    assign o_index_code = r_code;

    a_zc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid_a && r_mid.fmt == FMT_8) |-> (r_mid.zc <= 4'd7))
        else $error("8-bit code count exceeds three bits");

endmodule

@@ hdl/float_to_index_code_encoder_core.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_float_bits[63:0]
// output    out        o_valid / i_ready    o_index_code[19:0]
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data[2:0]
//
// five register stages: unpack, byte scan, byte select, count/shift, assemble
// one transfer per cycle sustained while i_ready holds the output unstalled
// synchronous active-low reset clears valid bits and config (format 0, binary64)
// each stage holds only while full and the next one is full and stalled
// bubbles collapse, so input is taken while a result waits at the output

module float_to_index_code_encoder_core import f2ic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_float_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [19:0] o_index_code,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [2:0]  i_cfg_data
);

    logic [2:0] r_code_format;
    logic       r_source_is_double;

    logic       w_unp_valid;
    logic       w_unp_ready;
    t_unp_s     w_unp_data;
    logic       w_lead_valid;
    logic       w_lead_ready;
    t_lead_s    w_lead_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_format      <= FMT_8;
            r_source_is_double <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FORMAT: r_code_format      <= i_cfg_data;
                CFG_DOUBLE: r_source_is_double <= i_cfg_data[0];
                default:    r_code_format      <= r_code_format;
            endcase
        end
    end

    f2ic_unpack u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_float_bits (i_float_bits),
        .i_fmt        (r_code_format),
        .i_dbl        (r_source_is_double),
        .o_valid      (w_unp_valid),
        .i_ready      (w_unp_ready),
        .o_data       (w_unp_data)
    );

    f2ic_lead u_lead (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_unp_valid),
        .o_ready (w_unp_ready),
        .i_data  (w_unp_data),
        .o_valid (w_lead_valid),
        .i_ready (w_lead_ready),
        .o_data  (w_lead_data)
    );

    f2ic_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_lead_valid),
        .o_ready      (w_lead_ready),
        .i_data       (w_lead_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_index_code (o_index_code)
    );

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready && w_unp_valid && w_lead_valid))
        else $error("input stalled with room in the pipeline");

endmodule
